/* rtl/rsc_pkg.sv */
// Package for the range sort coalescer: shared types and constants.
// Used by the controller, the datapath, the top level and the checker.
package rsc_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned StartW = 52;
  localparam int unsigned SizeW  = 52;
  localparam int unsigned MSizeW = 53;
  localparam int unsigned FlagW  = 4;
  localparam int unsigned HostW  = 47;
  localparam int unsigned PaddrW = 1;
  localparam int unsigned PdataW = 32;

  // register address of compare_mapping
  localparam logic [PaddrW-1:0] AddrCompareMapping = 1'b0;

  typedef enum logic [1:0] {
    StFill,
    StLoad,
    StRun
  } state_e;

  // one stored range
  typedef struct packed {
    logic [StartW-1:0] start;
    logic [SizeW-1:0]  size;
    logic [FlagW-1:0]  flags;
    logic [HostW-1:0]  host;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic pop_load;
    logic pop_merge;
    logic emit;
    logic last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_entry;
    logic merge_ok;
    logic out_free;
  } status_t;

endpackage

/* rtl/rsc_ctrl.sv */
// Controller state machine: fill the sorted chain, then drain and merge.
// Depends on rsc_pkg.
module rsc_ctrl import rsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    last_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StFill;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StFill: begin
        in_stall_o = 1'b0;
        cmd_o.push = in_valid_i;
        if (in_valid_i && last_i) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        // open the first merged range from the chain head
        cmd_o.pop_load = 1'b1;
        state_d        = StRun;
      end
      StRun: begin
        if (status_i.has_entry) begin
          if (status_i.merge_ok) begin
            cmd_o.pop_merge = 1'b1;
          end else if (status_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.pop_load = 1'b1;
          end
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = StFill;
        end
      end
      default: state_d = StFill;
    endcase
  end

endmodule

/* rtl/rsc_datapath.sv */
// Datapath: sorted register chain, open merged range and output register.
// Depends on rsc_pkg.
module rsc_datapath import rsc_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic              mode_i,
  input  entry_t            new_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [StartW-1:0] merged_start_o,
  output logic [MSizeW-1:0] merged_size_o,
  output logic [FlagW-1:0]  merged_flags_o,
  output logic [HostW-1:0]  merged_host_o,
  output logic              overflowed_o,
  output logic              last_merged_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  entry_t            chain_q [DEPTH];
  entry_t            chain_d [DEPTH];
  logic [DEPTH-1:0]  gt;
  logic [CntW-1:0]   count_q;
  logic              ovf_q;
  logic              full;

  logic [StartW-1:0] cs_q;
  logic [MSizeW-1:0] cz_q;
  logic [FlagW-1:0]  cf_q;
  logic [HostW-1:0]  ch_q;

  logic              ov_q;
  logic [StartW-1:0] os_q;
  logic [MSizeW-1:0] oz_q;
  logic [FlagW-1:0]  of_q;
  logic [HostW-1:0]  oh_q;
  logic              oo_q;
  logic              ol_q;

  logic [MSizeW-1:0] end_sum;
  logic [MSizeW:0]   host_sum;
  logic              contig;
  logic              map_ok;

  assign full = (count_q == Full);

  // insertion point: first slot empty or holding a larger start (ties stay ahead)
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CntW'(i) >= count_q) || (chain_q[i].start > new_i.start);
    end
  end

  // chain next value: shift right at the insertion point, or shift left on pop
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      chain_d[i] = chain_q[i];
      if (cmd_i.push && !full && gt[i]) begin
        if (i == 0) begin
          chain_d[i] = new_i;
        end else if (!gt[i-1]) begin
          chain_d[i] = new_i;
        end else begin
          chain_d[i] = chain_q[i-1];
        end
      end else if ((cmd_i.pop_load || cmd_i.pop_merge) && (i < DEPTH - 1)) begin
        chain_d[i] = chain_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      chain_q[i] <= chain_d[i];
    end
  end

  // merge test against the chain head; on contiguity the host offset is cz
  assign end_sum  = {1'b0, cs_q} + cz_q;
  assign contig   = (end_sum == {1'b0, chain_q[0].start});
  assign host_sum = {7'b0, ch_q} + {1'b0, cz_q};
  assign map_ok   = (cf_q == chain_q[0].flags) &&
                    (host_sum == {7'b0, chain_q[0].host});

  assign status_o.has_entry = (count_q != '0);
  assign status_o.merge_ok  = contig && (!mode_i || map_ok);
  assign status_o.out_free  = !ov_q || !out_stall_i;

  // fill count and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end else if (cmd_i.pop_load || cmd_i.pop_merge) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.emit && cmd_i.last) begin
        ovf_q <= 1'b0;
      end
    end
  end

  // open merged range
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_load) begin
      cs_q <= chain_q[0].start;
      cz_q <= {1'b0, chain_q[0].size};
      cf_q <= chain_q[0].flags;
      ch_q <= chain_q[0].host;
    end else if (cmd_i.pop_merge) begin
      cz_q <= cz_q + {1'b0, chain_q[0].size};
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      os_q <= cs_q;
      oz_q <= cz_q;
      of_q <= mode_i ? cf_q : '0;
      oh_q <= mode_i ? ch_q : '0;
      oo_q <= ovf_q;
      ol_q <= cmd_i.last;
    end
  end

  assign out_valid_o    = ov_q;
  assign merged_start_o = os_q;
  assign merged_size_o  = oz_q;
  assign merged_flags_o = of_q;
  assign merged_host_o  = oh_q;
  assign overflowed_o   = oo_q;
  assign last_merged_o  = ol_q;

endmodule

/* rtl/range_sort_coalescer_unit.sv */
// Range sort coalescer: one range inserted per cycle while filling, until the chain is
// full; after the last item, the load state opens the first merged range, then one
// stored range drains and merges per cycle, except while an emit waits on a stalled
// output; inputs stall during the drain.
// Reset clears the fill count, overflow flag, state and output valid;
// compare_mapping resets to 1.
module range_sort_coalescer_unit import rsc_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [StartW-1:0] guest_start_i,
  input  logic [SizeW-1:0]  range_size_i,
  input  logic [FlagW-1:0]  access_flags_i,
  input  logic [HostW-1:0]  host_start_i,
  input  logic              last_in_batch_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [StartW-1:0] merged_start_o,
  output logic [MSizeW-1:0] merged_size_o,
  output logic [FlagW-1:0]  merged_flags_o,
  output logic [HostW-1:0]  merged_host_o,
  output logic              overflowed_o,
  output logic              last_merged_o
);

  logic    mode_q;
  cmd_t    cmd;
  status_t status;
  entry_t  new_entry;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr == AddrCompareMapping)) begin
      mode_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == AddrCompareMapping) ? {{(PdataW-1){1'b0}}, mode_q} : '0;

  assign new_entry = '{start: guest_start_i, size: range_size_i,
                       flags: access_flags_i, host: host_start_i};

  rsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_in_batch_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  rsc_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (mode_q),
    .new_i          (new_entry),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .merged_start_o (merged_start_o),
    .merged_size_o  (merged_size_o),
    .merged_flags_o (merged_flags_o),
    .merged_host_o  (merged_host_o),
    .overflowed_o   (overflowed_o),
    .last_merged_o  (last_merged_o)
  );

endmodule

/* rtl/rsc_checker.sv */
// Port-level checker for the range sort coalescer, bound to the top level.
// Depends on rsc_pkg.
module rsc_checker import rsc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              pready,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              last_in_batch_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [MSizeW-1:0] merged_size_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(merged_size_o))
    else $error("stalled result changed");

  // closing a batch stops input during the drain
  a_close_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_in_batch_i |=> in_stall_o)
    else $error("input taken after batch close");

  // input stall only starts right after a closing transaction
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && last_in_batch_i))
    else $error("input stalled without batch close");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind range_sort_coalescer_unit rsc_checker u_rsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready          (pready),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .last_in_batch_i (last_in_batch_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .merged_size_o   (merged_size_o)
);
